### rtl/timer_task_table_macros.svh
// Assertion shorthands for the timer table RTL
`ifndef TIMER_TASK_TABLE_MACROS_SVH
`define TIMER_TASK_TABLE_MACROS_SVH

// Condition holds at every clock edge out of reset
`define TTT_ASSERT_ALWAYS(label, c, r, cond, msg) \
    label: assert property (@(posedge c) disable iff (!(r)) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define TTT_ASSERT_IMPLY(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!(r)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define TTT_ASSERT_NEXT(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!(r)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ttt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttt_pkg;

    typedef enum logic [2:0] {
        FUNC_RUN_AFTER      = 3'd0,
        FUNC_RUN_EVERY      = 3'd1,
        FUNC_RUN_NEXT_FRAME = 3'd2,
        FUNC_CANCEL         = 3'd3,
        FUNC_TICK           = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_ID_ASSIGNED = 2'd0,
        KIND_CANCEL_DONE = 2'd1,
        KIND_FIRED       = 2'd2,
        KIND_TICK_IDLE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    localparam int ID_W     = 32;
    localparam int REM_W    = 40;
    localparam int PERIOD_W = 31;

    localparam logic [REM_W-1:0]    REM_FLOOR       = {1'b1, {(REM_W-1){1'b0}}};
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST  = 31'd10000;
    localparam logic [ID_W-1:0]     FIRST_ID        = 32'd1;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [REM_W-1:0]    remaining;
        logic [PERIOD_W-1:0] period;
        logic                dead;
    } entry_t;

endpackage

`default_nettype wire

### rtl/ttt_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ttt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] delay_us;
    logic [31:0] cancel_id;
    logic [31:0] delta_us;

    modport source (output valid, func, delay_us, cancel_id, delta_us, input ready);
    modport sink   (input valid, func, delay_us, cancel_id, delta_us, output ready);
endinterface

`default_nettype wire

### rtl/ttt_evt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ttt_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] timer_id;
    logic        table_full;
    logic        last;

    modport source (output valid, kind, timer_id, table_full, last, input ready);
    modport sink   (input valid, kind, timer_id, table_full, last, output ready);
endinterface

`default_nettype wire

### rtl/ttt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/timer_task_table.sv
// Table of software timers held in one slot memory, times in whole microseconds.
// cmd channel: one operation per item (run_after, run_every, run_next_frame,
// cancel, tick). evt channel: result items; last marks the final one of an
// operation. cfg_we/cfg_wdata write the minimum period of periodic timers.
// An add passes through ST_FINISH, which loads its result into the output
// register once that register is free.
// Cancel and tick walk every entry below the fill count through the memory,
// one entry a cycle on its single read port while the walk is not halted.
// A tick rewrites survivors in place, packed towards slot 0, in the same pass.
// Fired ids are held one deep; a further firing while the output register is
// still full halts the walk until evt is taken.
// A new command is taken once the previous one has placed its last result in
// the output register, so one result may still wait on evt meanwhile.
// Reset empties the table, sets the next id to 1 and the minimum period to
// 10000; the memory itself is not cleared, entries past the fill count are
// never read.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_task_table_macros.svh"

module timer_task_table #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ttt_cmd_if.sink          cmd,
    ttt_evt_if.source        evt,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    ttt_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]              count_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              w_reg;
    logic [ttt_pkg::ID_W-1:0]      next_id_reg;
    logic [ttt_pkg::PERIOD_W-1:0]  min_period_reg;
    logic                          pend_valid_reg;
    logic                          evt_valid_reg;

    ttt_pkg::func_t                op_reg;
    logic [31:0]                   arg_reg;
    logic [ttt_pkg::ID_W-1:0]      pend_id_reg;
    ttt_pkg::kind_t                res_kind_reg;
    logic [ttt_pkg::ID_W-1:0]      res_id_reg;
    logic                          res_full_reg;
    ttt_pkg::kind_t                evt_kind_reg;
    logic [ttt_pkg::ID_W-1:0]      evt_id_reg;
    logic                          evt_full_reg;
    logic                          evt_last_reg;

    logic                          cmd_acc;
    logic                          out_free;
    logic                          is_add;
    logic                          is_sweep_op;
    logic                          room;
    logic [ttt_pkg::ID_W-1:0]      id_inc;
    logic [ttt_pkg::REM_W-1:0]     add_rem;
    logic [ttt_pkg::PERIOD_W-1:0]  add_period;
    logic [ttt_pkg::PERIOD_W-1:0]  min_eff;

    ttt_pkg::entry_t               entry_q;
    ttt_pkg::entry_t               wr_entry;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;

    logic [ttt_pkg::REM_W:0]       sub_w;
    logic [ttt_pkg::REM_W-1:0]     rem_sat;
    logic [ttt_pkg::REM_W-1:0]     rem_rearm;
    logic                          fires;
    logic                          keep;
    logic                          tick_op;
    logic                          live;
    logic                          stall;
    logic                          step_go;
    logic [CNT_W-1:0]              idx_plus;
    logic                          last_entry;
    logic                          emit_pend;
    logic                          emit_final;
    logic [CNT_W-1:0]              w_plus;

    assign cmd.ready = (state_reg == ttt_pkg::ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign out_free  = !evt_valid_reg || evt.ready;

    assign evt.valid      = evt_valid_reg;
    assign evt.kind       = evt_kind_reg;
    assign evt.timer_id   = evt_id_reg;
    assign evt.table_full = evt_full_reg;
    assign evt.last       = evt_last_reg;

    ttt_ram #(
        .WIDTH ($bits(ttt_pkg::entry_t)),
        .DEPTH (NUM_SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (entry_q)
    );

    // Decode of the incoming command
    always_comb
    begin
        is_add      = (cmd.func == ttt_pkg::FUNC_RUN_AFTER) ||
                      (cmd.func == ttt_pkg::FUNC_RUN_EVERY) ||
                      (cmd.func == ttt_pkg::FUNC_RUN_NEXT_FRAME);
        is_sweep_op = (cmd.func == ttt_pkg::FUNC_CANCEL) ||
                      (cmd.func == ttt_pkg::FUNC_TICK);
        room        = count_reg < CNT_W'(NUM_SLOTS);
        id_inc      = next_id_reg + ttt_pkg::ID_W'(1);
        min_eff     = (min_period_reg == '0) ? ttt_pkg::PERIOD_W'(1) : min_period_reg;
        add_rem     = '0;
        add_period  = '0;
        case (cmd.func)
            ttt_pkg::FUNC_RUN_AFTER:
            begin
                // clamp a negative delay to zero
                add_rem = cmd.delay_us[31] ? '0 : {8'd0, cmd.delay_us};
            end
            ttt_pkg::FUNC_RUN_EVERY:
            begin
                if (cmd.delay_us[31] || (cmd.delay_us[30:0] < min_eff))
                begin
                    add_period = min_eff;
                end
                else
                begin
                    add_period = cmd.delay_us[30:0];
                end
                add_rem = {9'd0, add_period};
            end
            default:
            begin
                add_rem    = '0;
                add_period = '0;
            end
        endcase
    end

    // Per-entry tick arithmetic on the entry most recently read
    always_comb
    begin
        sub_w     = {entry_q.remaining[ttt_pkg::REM_W-1], entry_q.remaining}
                    - {9'd0, arg_reg};
        // saturate at the lowest signed 40-bit value
        rem_sat   = (sub_w[ttt_pkg::REM_W] && !sub_w[ttt_pkg::REM_W-1])
                    ? ttt_pkg::REM_FLOOR : sub_w[ttt_pkg::REM_W-1:0];
        fires     = rem_sat[ttt_pkg::REM_W-1] || (rem_sat == '0);
        rem_rearm = rem_sat + {9'd0, entry_q.period};
        keep      = !fires || (entry_q.period != '0);
    end

    // Sweep step control
    always_comb
    begin
        tick_op    = (op_reg == ttt_pkg::FUNC_TICK);
        live       = !entry_q.dead;
        stall      = tick_op && live && fires && pend_valid_reg && !out_free;
        step_go    = (state_reg == ttt_pkg::ST_SWEEP) && !stall;
        idx_plus   = CNT_W'(idx_reg) + CNT_W'(1);
        last_entry = idx_plus >= count_reg;
        w_plus     = w_reg + CNT_W'(1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttt_pkg::ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (is_add)
                    begin
                        state_next = ttt_pkg::ST_FINISH;
                    end
                    else if (is_sweep_op)
                    begin
                        state_next = (count_reg == '0) ? ttt_pkg::ST_FINISH
                                                       : ttt_pkg::ST_SWEEP;
                    end
                end
            end
            ttt_pkg::ST_SWEEP:
            begin
                if (step_go && last_entry)
                begin
                    state_next = ttt_pkg::ST_FINISH;
                end
            end
            ttt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ttt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttt_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory port and result-load controls
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_entry   = entry_q;
        rd_en      = 1'b0;
        rd_addr    = '0;
        emit_pend  = 1'b0;
        emit_final = 1'b0;
        case (state_reg)
            ttt_pkg::ST_IDLE:
            begin
                if (cmd_acc && is_add && room)
                begin
                    wr_en              = 1'b1;
                    wr_addr            = count_reg[IDX_W-1:0];
                    wr_entry.id        = next_id_reg;
                    wr_entry.remaining = add_rem;
                    wr_entry.period    = add_period;
                    wr_entry.dead      = 1'b0;
                end
                if (cmd_acc && is_sweep_op && (count_reg != '0))
                begin
                    rd_en = 1'b1;
                end
            end
            ttt_pkg::ST_SWEEP:
            begin
                if (step_go)
                begin
                    if (!last_entry)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_plus[IDX_W-1:0];
                    end
                    if (tick_op)
                    begin
                        // pack survivors down to the write pointer
                        if (live && keep)
                        begin
                            wr_en              = 1'b1;
                            wr_addr            = w_reg[IDX_W-1:0];
                            wr_entry.remaining = fires ? rem_rearm : rem_sat;
                            wr_entry.dead      = 1'b0;
                        end
                        emit_pend = live && fires && pend_valid_reg;
                    end
                    else if (entry_q.id == arg_reg)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = idx_reg;
                        wr_entry.dead = 1'b1;
                    end
                end
            end
            ttt_pkg::ST_FINISH:
            begin
                emit_final = out_free;
            end
            default:
            begin
                emit_final = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ttt_pkg::ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            w_reg          <= '0;
            next_id_reg    <= ttt_pkg::FIRST_ID;
            min_period_reg <= ttt_pkg::MIN_PERIOD_RST;
            pend_valid_reg <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                min_period_reg <= cfg_wdata;
            end
            if (cmd_acc)
            begin
                idx_reg        <= '0;
                w_reg          <= '0;
                pend_valid_reg <= 1'b0;
                if (is_add && room)
                begin
                    count_reg   <= count_reg + CNT_W'(1);
                    // skip id zero on wrap
                    next_id_reg <= (id_inc == '0) ? ttt_pkg::FIRST_ID : id_inc;
                end
            end
            if (step_go)
            begin
                idx_reg <= idx_plus[IDX_W-1:0];
                if (tick_op)
                begin
                    if (live && keep)
                    begin
                        w_reg <= w_plus;
                    end
                    if (live && fires)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                    if (last_entry)
                    begin
                        count_reg <= (live && keep) ? w_plus : w_reg;
                    end
                end
            end
            if (emit_pend || emit_final)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            op_reg  <= ttt_pkg::func_t'(cmd.func);
            arg_reg <= (cmd.func == ttt_pkg::FUNC_CANCEL) ? cmd.cancel_id : cmd.delta_us;
            if (is_add)
            begin
                res_kind_reg <= ttt_pkg::KIND_ID_ASSIGNED;
                res_id_reg   <= room ? next_id_reg : '0;
                res_full_reg <= !room;
            end
            else
            begin
                res_kind_reg <= ttt_pkg::KIND_CANCEL_DONE;
                res_id_reg   <= '0;
                res_full_reg <= 1'b0;
            end
        end
        if (step_go && tick_op && live && fires)
        begin
            pend_id_reg <= entry_q.id;
        end
        if (emit_pend)
        begin
            evt_kind_reg <= ttt_pkg::KIND_FIRED;
            evt_id_reg   <= pend_id_reg;
            evt_full_reg <= 1'b0;
            evt_last_reg <= 1'b0;
        end
        else if (emit_final)
        begin
            evt_last_reg <= 1'b1;
            if (op_reg == ttt_pkg::FUNC_TICK)
            begin
                evt_kind_reg <= pend_valid_reg ? ttt_pkg::KIND_FIRED
                                               : ttt_pkg::KIND_TICK_IDLE;
                evt_id_reg   <= pend_valid_reg ? pend_id_reg : '0;
                evt_full_reg <= 1'b0;
            end
            else
            begin
                evt_kind_reg <= res_kind_reg;
                evt_id_reg   <= res_id_reg;
                evt_full_reg <= res_full_reg;
            end
        end
    end

    `TTT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(NUM_SLOTS), "fill count past table size")
    `TTT_ASSERT_ALWAYS(a_id_nonzero, clk, rst_n, next_id_reg != '0, "next id is zero")
    `TTT_ASSERT_IMPLY(a_pack_behind, clk, rst_n, state_reg == ttt_pkg::ST_SWEEP, w_reg <= CNT_W'(idx_reg), "pack pointer ahead of read index")
    `TTT_ASSERT_NEXT(a_add_count, clk, rst_n, cmd_acc && is_add && room, count_reg == $past(count_reg) + CNT_W'(1), "add did not grow the table")

endmodule

`default_nettype wire

### sim/timer_task_table_checker.sv
`timescale 1ns / 1ps

module timer_task_table_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ttt_cmd_if                           cmd,
    ttt_evt_if                           evt,
    input  logic                         cfg_we,
    input  logic [ttt_pkg::PERIOD_W-1:0] cfg_wdata,
    output int                           fail_count,
    output int                           pending
);

    typedef struct packed {
        ttt_pkg::kind_t           kind;
        logic [ttt_pkg::ID_W-1:0] timer_id;
        logic                     table_full;
        logic                     last;
    } timer_event_t;

    localparam longint OVERDUE_FLOOR = -(longint'(1) <<< (ttt_pkg::REM_W - 1));

    logic [ttt_pkg::ID_W-1:0]     slot_ids    [NUM_SLOTS];
    logic [ttt_pkg::REM_W-1:0]    slot_left   [NUM_SLOTS];
    logic [ttt_pkg::PERIOD_W-1:0] slot_reload [NUM_SLOTS];
    logic                         slot_gone   [NUM_SLOTS];
    int                           slots_used;
    logic [ttt_pkg::ID_W-1:0]     id_next;
    logic [ttt_pkg::PERIOD_W-1:0] period_floor;
    timer_event_t                 owed_events[$];
    timer_event_t                 seen;
    timer_event_t                 owed;
    int                           errors;

    task automatic owe(input ttt_pkg::kind_t k, input logic [ttt_pkg::ID_W-1:0] id,
                       input logic full, input logic fin);
        timer_event_t e;
        e.kind       = k;
        e.timer_id   = id;
        e.table_full = full;
        e.last       = fin;
        owed_events = {owed_events, e};
    endtask

    task automatic add_timer(input longint start,
                             input logic [ttt_pkg::PERIOD_W-1:0] reload);
        if (slots_used >= NUM_SLOTS)
        begin
            owe(ttt_pkg::KIND_ID_ASSIGNED, '0, 1'b1, 1'b1);
        end
        else
        begin
            slot_ids[slots_used]    = id_next;
            slot_left[slots_used]   = start[ttt_pkg::REM_W-1:0];
            slot_reload[slots_used] = reload;
            slot_gone[slots_used]   = 1'b0;
            slots_used++;
            owe(ttt_pkg::KIND_ID_ASSIGNED, id_next, 1'b0, 1'b1);
            // id 0 means none, so skip it on wrap
            id_next = id_next + 1'b1;
            if (id_next == '0)
                id_next = ttt_pkg::FIRST_ID;
        end
    endtask

    task automatic cancel_timers(input logic [ttt_pkg::ID_W-1:0] id);
        for (int i = 0; i < slots_used; i++)
        begin
            if (slot_ids[i] == id)
                slot_gone[i] = 1'b1;
        end
        owe(ttt_pkg::KIND_CANCEL_DONE, '0, 1'b0, 1'b1);
    endtask

    task automatic tick_timers(input logic [ttt_pkg::ID_W-1:0] delta);
        logic [ttt_pkg::ID_W-1:0] fired[$];
        longint                   left;
        int                       kept;
        kept = 0;
        for (int i = 0; i < slots_used; i++)
        begin
            if (!slot_gone[i])
            begin
                left = longint'($signed(slot_left[i])) - longint'({32'd0, delta});
                if (left < OVERDUE_FLOOR)
                    left = OVERDUE_FLOOR;
                if (left <= 0)
                begin
                    fired = {fired, slot_ids[i]};
                    if (slot_reload[i] != '0)
                        left = left + longint'({33'd0, slot_reload[i]});
                    else
                        slot_gone[i] = 1'b1;
                end
                slot_left[i] = left[ttt_pkg::REM_W-1:0];
            end
        end
        // pack survivors towards slot 0, order kept
        for (int i = 0; i < slots_used; i++)
        begin
            if (!slot_gone[i])
            begin
                slot_ids[kept]    = slot_ids[i];
                slot_left[kept]   = slot_left[i];
                slot_reload[kept] = slot_reload[i];
                slot_gone[kept]   = 1'b0;
                kept++;
            end
        end
        slots_used = kept;
        if (fired.size() == 0)
            owe(ttt_pkg::KIND_TICK_IDLE, '0, 1'b0, 1'b1);
        else
            foreach (fired[k])
                owe(ttt_pkg::KIND_FIRED, fired[k], 1'b0, k == fired.size() - 1);
    endtask

    task automatic take_command(input logic [2:0] op, input logic [31:0] delay_raw,
                                input logic [ttt_pkg::ID_W-1:0] cid,
                                input logic [31:0] delta);
        longint want;
        longint lowest;
        want = longint'($signed(delay_raw));
        case (op)
            ttt_pkg::FUNC_RUN_AFTER:
            begin
                if (want < 0)
                    want = 0;
                add_timer(want, '0);
            end
            ttt_pkg::FUNC_RUN_EVERY:
            begin
                lowest = (period_floor == '0) ? longint'(1)
                                              : longint'({33'd0, period_floor});
                if (want < lowest)
                    want = lowest;
                add_timer(want, want[ttt_pkg::PERIOD_W-1:0]);
            end
            ttt_pkg::FUNC_RUN_NEXT_FRAME: add_timer(0, '0);
            ttt_pkg::FUNC_CANCEL:         cancel_timers(cid);
            ttt_pkg::FUNC_TICK:           tick_timers(delta);
            default:                      ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_used   = 0;
            id_next      = ttt_pkg::FIRST_ID;
            period_floor = ttt_pkg::MIN_PERIOD_RST;
            errors       = 0;
            owed_events.delete();
        end
        else
        begin
            if (evt.valid === 1'b1 && evt.ready === 1'b1)
            begin
                seen.kind       = ttt_pkg::kind_t'(evt.kind);
                seen.timer_id   = evt.timer_id;
                seen.table_full = evt.table_full;
                seen.last       = evt.last;
                if (owed_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected event: expected none, got kind=%0d id=%0d full=%0b last=%0b",
                             $time, seen.kind, seen.timer_id, seen.table_full, seen.last);
                end
                else
                begin
                    owed = owed_events.pop_front();
                    if (seen !== owed)
                    begin
                        errors++;
                        $display("%0t: event mismatch: expected kind=%0d id=%0d full=%0b last=%0b, got kind=%0d id=%0d full=%0b last=%0b",
                                 $time, owed.kind, owed.timer_id, owed.table_full, owed.last,
                                 seen.kind, seen.timer_id, seen.table_full, seen.last);
                    end
                end
            end
            if (cfg_we === 1'b1)
                period_floor = cfg_wdata;
            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
                take_command(cmd.func, cmd.delay_us, cmd.cancel_id, cmd.delta_us);
        end
        fail_count <= errors;
        pending    <= owed_events.size();
    end

endmodule

### sim/timer_task_table_tb.sv
`timescale 1ns / 1ps

module timer_task_table_tb;

    localparam int NUM_SLOTS       = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = NUM_SLOTS + 8;
    localparam int STALL_LIMIT     = 5000;
    localparam int PHASE_ITEMS     = 6;
    localparam int OVERDUE_TICKS   = 130;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [ttt_pkg::PERIOD_W-1:0] cfg_wdata;
    int                           fail_count;
    int                           pending;
    int                           cmd_idle_mode = 1;
    int                           evt_idle_mode = 1;
    int                           hold_off_asked = 0;
    logic [ttt_pkg::ID_W-1:0]     newest_id = '0;

    ttt_cmd_if cmd_ch ();
    ttt_evt_if evt_ch ();

    timer_task_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .evt       (evt_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    timer_task_table_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .evt        (evt_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // no gap in mode 0; else mostly no gap or a short one, the odd long one
    function automatic int pick_gap(input int mode);
        int roll;
        if (mode == 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < ((mode == 1) ? 75 : 45))
            return 0;
        if (roll < 96)
            return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    task automatic offer(input logic [2:0] op, input logic [31:0] delay,
                         input logic [31:0] cid, input logic [31:0] delta);
        int gap;
        gap = pick_gap(cmd_idle_mode);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.func      <= op;
        cmd_ch.delay_us  <= delay;
        cmd_ch.cancel_id <= cid;
        cmd_ch.delta_us  <= delta;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // drop valid and wait until every owed event has been taken
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_min_period(input logic [ttt_pkg::PERIOD_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_item(output bit counted);
        int          roll;
        int          shape;
        logic [2:0]  op;
        logic [31:0] delay;
        logic [31:0] cid;
        logic [31:0] delta;
        roll  = $urandom_range(0, 99);
        shape = $urandom_range(0, 99);
        delay = $urandom;
        cid   = $urandom;
        delta = $urandom;
        if (roll < 44)
        begin
            op = (roll < 29) ? ttt_pkg::FUNC_RUN_AFTER : ttt_pkg::FUNC_RUN_EVERY;
            if (shape < 70)
                delay = $urandom_range(0, 400);
            else if (shape < 85)
                delay = $urandom | 32'h8000_0000;
        end
        else if (roll < 51)
        begin
            op = ttt_pkg::FUNC_RUN_NEXT_FRAME;
        end
        else if (roll < 66)
        begin
            op = ttt_pkg::FUNC_CANCEL;
            // aim mostly at live ids
            if (shape < 55)
                cid = newest_id - $urandom_range(0, 12);
            else if (shape < 80)
                cid = $urandom_range(1, newest_id + 1);
        end
        else if (roll < 96)
        begin
            op = ttt_pkg::FUNC_TICK;
            if (shape < 90)
                delta = $urandom_range(0, 250);
        end
        else
        begin
            op = $urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI);
        end
        offer(op, delay, cid, delta);
        counted = (op <= ttt_pkg::FUNC_TICK);
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        int gap_left;
        int served;
        gap_left = 0;
        served   = 0;
        evt_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1 &&
                evt_ch.kind == ttt_pkg::KIND_ID_ASSIGNED && evt_ch.table_full === 1'b0)
                newest_id <= evt_ch.timer_id;
            if (served != hold_off_asked)
            begin
                served   = hold_off_asked;
                gap_left = HOLD_OFF_CYCLES;
            end
            if (gap_left > 0)
            begin
                evt_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                evt_ch.ready <= 1'b1;
                gap_left = pick_gap(evt_idle_mode);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                (evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timer_task_table_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ttt_pkg::PERIOD_W-1:0] phase_floor [5];
        int                           counted_items;
        bit                           counted;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.func      <= ttt_pkg::FUNC_RUN_AFTER;
        cmd_ch.delay_us  <= '0;
        cmd_ch.cancel_id <= '0;
        cmd_ch.delta_us  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset minimum period
        cmd_idle_mode = 1;
        offer(ttt_pkg::FUNC_RUN_NEXT_FRAME, $urandom, $urandom, $urandom);
        offer(ttt_pkg::FUNC_RUN_AFTER, 32'hFFFF_FFFB, $urandom, $urandom);
        offer(ttt_pkg::FUNC_RUN_AFTER, 32'h8000_0000, $urandom, $urandom);
        offer(ttt_pkg::FUNC_RUN_AFTER, 32'h7FFF_FFFF, $urandom, $urandom);
        offer(ttt_pkg::FUNC_RUN_EVERY, 32'd5, $urandom, $urandom);
        offer(ttt_pkg::FUNC_RUN_EVERY, 32'hFFFF_FFFF, $urandom, $urandom);
        offer(ttt_pkg::FUNC_CANCEL, $urandom, 32'd3, $urandom);
        offer(ttt_pkg::FUNC_CANCEL, $urandom, 32'hFFFF_FFFF, $urandom);
        offer(ttt_pkg::FUNC_TICK, $urandom, $urandom, 32'd0);
        offer(ttt_pkg::FUNC_TICK, $urandom, $urandom, 32'd9999);
        offer(ttt_pkg::FUNC_TICK, $urandom, $urandom, 32'd1);
        offer(FUNC_UNUSED_HI, $urandom, $urandom, $urandom);
        offer(ttt_pkg::FUNC_TICK, $urandom, $urandom, 32'hFFFF_FFFF);
        // fill the table, then try adds while a cancelled entry still holds a slot
        repeat (14)
            offer(ttt_pkg::FUNC_RUN_AFTER, $urandom_range(100, 2000), $urandom, $urandom);
        offer(ttt_pkg::FUNC_RUN_NEXT_FRAME, $urandom, $urandom, $urandom);
        offer(ttt_pkg::FUNC_CANCEL, $urandom, 32'd7, $urandom);
        offer(ttt_pkg::FUNC_RUN_EVERY, 32'd0, $urandom, $urandom);
        offer(ttt_pkg::FUNC_TICK, $urandom, $urandom, 32'd0);

        // drive periodic entries deep overdue until remaining time saturates
        set_min_period(31'd1);
        cmd_idle_mode = 0;
        evt_idle_mode <= 0;
        offer(ttt_pkg::FUNC_RUN_EVERY, 32'd1, $urandom, $urandom);
        repeat (OVERDUE_TICKS)
            offer(ttt_pkg::FUNC_TICK, $urandom, $urandom, 32'hFFFF_FFFF);

        phase_floor = '{31'd0, 31'($urandom_range(20, 300)), 31'h7FFF_FFFF,
                        31'($urandom_range(1, 2000)), ttt_pkg::MIN_PERIOD_RST};
        for (int p = 0; p < 5; p++)
        begin
            set_min_period(phase_floor[p]);
            cmd_idle_mode = p % 3;
            evt_idle_mode <= (p + 1) % 3;
            if (p == 1)
                hold_off_asked <= hold_off_asked + 1;
            offer(ttt_pkg::FUNC_RUN_EVERY, 32'd0, $urandom, $urandom);
            counted_items = 0;
            while (counted_items < PHASE_ITEMS)
            begin
                random_item(counted);
                if (counted)
                    counted_items++;
            end
        end

        settle();
        if (fail_count == 0)
            $display("timer_task_table_tb: done, clean");
        else
            $display("timer_task_table_tb: done, errors");
        $finish;
    end

endmodule
